// ===== hdl/ccd_pkg.sv =====
// Shared widths, register indexes and reset values for the center crop decimator.
package ccd_pkg;

  // Field widths
  localparam int DIM_W   = 12;
  localparam int SCALE_W = 7;
  localparam int PHASE_W = 6;
  localparam int PIX_W   = 24;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 3;
  // out_* times scale: 4095 * 64 fits in 18 bits, one spare for the compare
  localparam int REQ_W   = 19;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SCALE      = 3'd0,
    REG_OUT_ROWS   = 3'd1,
    REG_OUT_COLS   = 3'd2,
    REG_CENTER     = 3'd3,
    REG_SRC_WIDTH  = 3'd4,
    REG_SRC_HEIGHT = 3'd5
  } reg_index_t;

  // Reset values
  localparam logic [SCALE_W-1:0] SCALE_RST   = 7'd5;
  localparam logic [PHASE_W-1:0] HALF_RST    = 6'd2;
  localparam logic [DIM_W-1:0]   OUT_DIM_RST = 12'd48;
  localparam logic [DIM_W-1:0]   SRC_DIM_RST = 12'd240;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = 7'd64;

endpackage

// ===== hdl/center_crop_decimator.sv =====
// Center crop decimator: nearest-neighbor downsampler with optional centered crop.
//
// Takes one source pixel per item in raster order and passes on the center
// pixel of each scale x scale block, out_rows x out_cols results per frame;
// frame_last marks the final one. A frame whose source is too small gives a
// single size_error item on its frame-start pixel. The block accepts one item
// every clock while in_stall is low; an item moves through an input register
// and then a result register, where its result, if it has one, is offered.
// in_stall rises only when both registers are full and out_stall holds the
// result. Block size, half size, crop offsets and the size check are recomputed
// from the registers into flops each cycle, so a register write reaches them
// through those flops.
module center_crop_decimator
  import ccd_pkg::*;
#(
  parameter int MAX_DIM    = 4096,
  parameter int PIXEL_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  // configuration write port
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // source pixel channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] pixel_in,
  input  logic             frame_start,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] pixel_out,
  output logic             frame_last,
  output logic             size_error
);

  localparam int ROW_W  = $clog2(MAX_DIM);
  localparam int CMP_W  = (ROW_W > DIM_W) ? ROW_W : DIM_W;
  localparam int KEEP_W = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_DIM - 1);

  // Configuration registers
  logic [SCALE_W-1:0] scale;
  logic [DIM_W-1:0]   out_rows;
  logic [DIM_W-1:0]   out_cols;
  logic               center_enable;
  logic [DIM_W-1:0]   src_width;
  logic [DIM_W-1:0]   src_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale         <= SCALE_RST;
      out_rows      <= OUT_DIM_RST;
      out_cols      <= OUT_DIM_RST;
      center_enable <= 1'b1;
      src_width     <= SRC_DIM_RST;
      src_height    <= SRC_DIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:      scale         <= cfg_data[SCALE_W-1:0];
        REG_OUT_ROWS:   out_rows      <= cfg_data[DIM_W-1:0];
        REG_OUT_COLS:   out_cols      <= cfg_data[DIM_W-1:0];
        REG_CENTER:     center_enable <= cfg_data[0];
        REG_SRC_WIDTH:  src_width     <= cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height    <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived geometry: clamped scale, sampling phase, crop offsets, size check
  logic [SCALE_W-1:0] blk_scale, blk_scale_next;
  logic [PHASE_W-1:0] blk_half, blk_half_next;
  logic [DIM_W-1:0]   off_x, off_x_next;
  logic [DIM_W-1:0]   off_y, off_y_next;
  logic               size_bad, size_bad_next;
  logic [REQ_W-1:0]   req_w, req_h;

  always_comb begin
    if (scale == '0) begin
      blk_scale_next = SCALE_W'(1);
    end else if (scale > SCALE_MAX) begin
      blk_scale_next = SCALE_MAX;
    end else begin
      blk_scale_next = scale;
    end
    blk_half_next = PHASE_W'(blk_scale_next >> 1);
    req_w = REQ_W'(out_cols) * REQ_W'(blk_scale_next);
    req_h = REQ_W'(out_rows) * REQ_W'(blk_scale_next);
    size_bad_next = (req_w > REQ_W'(src_width)) || (req_h > REQ_W'(src_height));
    if (center_enable && !size_bad_next) begin
      off_x_next = DIM_W'((REQ_W'(src_width) - req_w) >> 1);
      off_y_next = DIM_W'((REQ_W'(src_height) - req_h) >> 1);
    end else begin
      off_x_next = '0;
      off_y_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_scale <= SCALE_RST;
      blk_half  <= HALF_RST;
      off_x     <= '0;
      off_y     <= '0;
      size_bad  <= 1'b0;
    end else begin
      blk_scale <= blk_scale_next;
      blk_half  <= blk_half_next;
      off_x     <= off_x_next;
      off_y     <= off_y_next;
      size_bad  <= size_bad_next;
    end
  end

  // Pipeline control
  logic              s1_valid;
  logic [KEEP_W-1:0] s1_pixel;
  logic              s1_start;
  logic              out_free;
  logic              fire;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign fire     = s1_valid && out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_pixel <= pixel_in[KEEP_W-1:0];
      s1_start <= frame_start;
    end
  end

  // Scan state
  logic [DIM_W-1:0]   src_col, src_col_next, col_c;
  logic [ROW_W-1:0]   src_row, src_row_next, row_c;
  logic [PHASE_W-1:0] col_phase, col_phase_next, cp_c;
  logic [PHASE_W-1:0] row_phase, row_phase_next, rp_c;
  logic [DIM_W-1:0]   out_col_index, out_col_index_next, oci_c;
  logic [DIM_W-1:0]   out_row_index, out_row_index_next, ori_c;
  logic               frame_done, frame_done_next, done_c;

  logic               zero_out;
  logic               col_in, row_in, hit, last;
  logic [PHASE_W:0]   cp_inc, rp_inc;
  logic [DIM_W:0]     col_inc;
  logic               res_valid, res_err, res_last;

  assign zero_out = (out_rows == '0) || (out_cols == '0);

  // One item: sample decision and counter advance
  always_comb begin
    // frame start restarts the scan at source origin
    col_c  = s1_start ? '0 : src_col;
    row_c  = s1_start ? '0 : src_row;
    cp_c   = s1_start ? '0 : col_phase;
    rp_c   = s1_start ? '0 : row_phase;
    oci_c  = s1_start ? '0 : out_col_index;
    ori_c  = s1_start ? '0 : out_row_index;
    done_c = s1_start ? 1'b0 : frame_done;

    col_in = (col_c >= off_x) && (oci_c < out_cols);
    row_in = (CMP_W'(row_c) >= CMP_W'(off_y)) && (ori_c < out_rows);
    hit    = col_in && row_in && (cp_c == blk_half) && (rp_c == blk_half);
    last   = ((DIM_W+1)'(ori_c) + 1'b1 == (DIM_W+1)'(out_rows)) &&
             ((DIM_W+1)'(oci_c) + 1'b1 == (DIM_W+1)'(out_cols));

    cp_inc  = (PHASE_W+1)'(cp_c) + 1'b1;
    rp_inc  = (PHASE_W+1)'(rp_c) + 1'b1;
    col_inc = (DIM_W+1)'(col_c) + 1'b1;

    src_col_next       = col_c;
    src_row_next       = row_c;
    col_phase_next     = cp_c;
    row_phase_next     = rp_c;
    out_col_index_next = oci_c;
    out_row_index_next = ori_c;
    frame_done_next    = done_c;

    res_valid = 1'b0;
    res_err   = 1'b0;
    res_last  = 1'b0;

    if (s1_start && size_bad) begin
      res_valid       = 1'b1;
      res_err         = 1'b1;
      frame_done_next = 1'b1;
    end else if (s1_start && zero_out) begin
      frame_done_next = 1'b1;
    end else if (!done_c) begin
      if (hit) begin
        res_valid = 1'b1;
        res_last  = last;
      end
      if (hit && last) begin
        frame_done_next = 1'b1;
      end else begin
        // column phase within the block
        if (col_in) begin
          if (cp_inc >= blk_scale) begin
            col_phase_next     = '0;
            out_col_index_next = oci_c + 1'b1;
          end else begin
            col_phase_next = cp_inc[PHASE_W-1:0];
          end
        end
        // end of a source line
        if (col_inc >= (DIM_W+1)'(src_width)) begin
          src_col_next       = '0;
          col_phase_next     = '0;
          out_col_index_next = '0;
          if (row_in) begin
            if (rp_inc >= blk_scale) begin
              row_phase_next     = '0;
              out_row_index_next = ori_c + 1'b1;
            end else begin
              row_phase_next = rp_inc[PHASE_W-1:0];
            end
          end
          if (row_c != ROW_MAX) begin
            src_row_next = row_c + 1'b1;
          end
        end else begin
          src_col_next = col_inc[DIM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col       <= '0;
      src_row       <= '0;
      col_phase     <= '0;
      row_phase     <= '0;
      out_col_index <= '0;
      out_row_index <= '0;
      frame_done    <= 1'b1;
    end else if (fire) begin
      src_col       <= src_col_next;
      src_row       <= src_row_next;
      col_phase     <= col_phase_next;
      row_phase     <= row_phase_next;
      out_col_index <= out_col_index_next;
      out_row_index <= out_row_index_next;
      frame_done    <= frame_done_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fire && res_valid) begin
      pixel_out  <= res_err ? '0 : PIX_W'(s1_pixel);
      frame_last <= res_last;
      size_error <= res_err;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the center crop decimator.
module tb_top;
  import ccd_pkg::*;

  localparam int MAX_DIM      = 4096;
  localparam int LONG_HOLD    = 120;   // cycles of held-off results under pressure
  localparam int DRAIN_CYCLES = 6;     // covers the two-stage pipe and the config flops
  localparam int WATCHDOG     = 3000;
  localparam int RANDOM_ITEMS = 700;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             size_err;
  } crop_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;
  logic             out_valid;
  logic             out_stall;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;
  logic             size_error;

  // Register copies used by the crop predictor
  logic [SCALE_W-1:0] reg_scale;
  logic [DIM_W-1:0]   reg_out_rows, reg_out_cols, reg_src_w, reg_src_h;
  logic               reg_center;

  // Walk position through the source frame
  logic [DIM_W-1:0]   walk_col, walk_row, blk_col, blk_row;
  logic [PHASE_W:0]   col_ph, row_ph;  // one spare bit so the count can reach 64
  bit                 frame_idle;

  crop_result_t       sampled_q[$];
  int                 errors = 0;
  int unsigned        fed_items = 0;
  int unsigned        stall_cycles = 0;
  bit                 no_idle = 1'b0;
  bit                 hold_results = 1'b0;

  center_crop_decimator DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_in   (pixel_in),
    .frame_start(frame_start),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .frame_last (frame_last),
    .size_error (size_error)
  );

  always #1 clk = ~clk;

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom());
  endfunction

  // Crop predictor: advances the walk by one accepted pixel and queues any
  // sampled pixel. Returns 0 when the pixel is simply dropped.
  function automatic bit predict_sample(logic [PIX_W-1:0] pix, logic fs);
    int unsigned s, req_w, req_h, off_x, off_y;
    bit col_in, row_in, last;
    s = (reg_scale == 0) ? 1 : (reg_scale > SCALE_MAX) ? SCALE_MAX : reg_scale;
    req_w = reg_out_cols * s;
    req_h = reg_out_rows * s;
    off_x = 0;
    off_y = 0;
    if (fs) begin
      walk_col = '0; walk_row = '0; col_ph = '0; row_ph = '0;
      blk_col = '0; blk_row = '0;
      frame_idle = 1'b0;
      if (req_w > reg_src_w || req_h > reg_src_h) begin
        sampled_q.push_back('{pixel: '0, last: 1'b0, size_err: 1'b1});
        frame_idle = 1'b1;
        return 1'b1;
      end
      if (reg_out_rows == 0 || reg_out_cols == 0) begin
        frame_idle = 1'b1;
        return 1'b1;
      end
    end
    if (frame_idle) return 1'b0;

    if (reg_center && reg_src_w >= req_w && reg_src_h >= req_h) begin
      off_x = (reg_src_w - req_w) / 2;
      off_y = (reg_src_h - req_h) / 2;
    end
    col_in = walk_col >= off_x && blk_col < reg_out_cols;
    row_in = walk_row >= off_y && blk_row < reg_out_rows;

    // block center hit
    if (col_in && row_in && col_ph == s / 2 && row_ph == s / 2) begin
      last = (blk_row + 1 == reg_out_rows) && (blk_col + 1 == reg_out_cols);
      sampled_q.push_back('{pixel: pix, last: last, size_err: 1'b0});
      if (last) begin
        frame_idle = 1'b1;
        return 1'b1;
      end
    end

    if (col_in) begin
      col_ph++;
      if (col_ph >= s) begin
        col_ph = '0;
        blk_col++;
      end
    end
    // end of source line
    if (walk_col + 1 >= reg_src_w) begin
      walk_col = '0;
      col_ph = '0;
      blk_col = '0;
      if (row_in) begin
        row_ph++;
        if (row_ph >= s) begin
          row_ph = '0;
          blk_row++;
        end
      end
      if (walk_row + 1 < MAX_DIM) walk_row++;
    end else begin
      walk_col++;
    end
    return 1'b1;
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_in    <= pix;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    void'(predict_sample(pix, fs));
    fed_items++;
  endtask

  // Sender stops until every sampled pixel is out and the pipe is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sampled_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // count pixels of random content; optional frame start on the first,
  // optional random pauses until everything expected has come out
  task automatic send_frame(input int unsigned count, input bit start, input bit pauses);
    for (int unsigned i = 0; i < count; i++) begin
      if (pauses && i > 0 && $urandom_range(0, 99) == 0) wait_drained();
      send_pixel(rand_pixel(), start && i == 0);
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      REG_SCALE:      reg_scale    = val[SCALE_W-1:0];
      REG_OUT_ROWS:   reg_out_rows = val[DIM_W-1:0];
      REG_OUT_COLS:   reg_out_cols = val[DIM_W-1:0];
      REG_CENTER:     reg_center   = val[0];
      REG_SRC_WIDTH:  reg_src_w    = val[DIM_W-1:0];
      REG_SRC_HEIGHT: reg_src_h    = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  // All six registers, written only once the block is idle
  task automatic set_config(input int unsigned sc, input int unsigned rows,
                            input int unsigned cols, input int unsigned ctr,
                            input int unsigned w, input int unsigned h);
    wait_drained();
    write_reg(REG_SCALE, sc);
    write_reg(REG_OUT_ROWS, rows);
    write_reg(REG_OUT_COLS, cols);
    write_reg(REG_CENTER, ctr);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    set_config(2, 2, 2, 0, 4, 4);
    // no frame open: dropped
    send_pixel(24'hFFFFFF, 1'b0);
    // frame start partway through a frame restarts at the origin
    send_frame(3, 1'b1, 1'b0);
    // sampled pixels alternate all-zero and all-one, then one extra pixel
    for (int unsigned i = 0; i < 17; i++)
      send_pixel((i % 4 == 1) ? 24'h000000 : 24'hFFFFFF, i == 0);
    // source too small: error item, then idle
    set_config(2, 3, 2, 0, 4, 4);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    // zero output rows: nothing comes out
    set_config(2, 0, 2, 1, 4, 4);
    send_pixel(24'h123456, 1'b1);
  endtask

  task automatic test_back_pressure();
    set_config(1, 8, 8, 0, 8, 8);
    no_idle = 1'b1;
    hold_results = 1'b1;
    send_frame(64, 1'b1, 1'b0);
    // half a frame, drain fully, then the rest of it with no idling
    send_frame(32, 1'b1, 1'b0);
    wait_drained();
    send_frame(32, 1'b0, 1'b0);
    no_idle = 1'b0;
  endtask

  task automatic test_scale_limits();
    // wide block, centered: one center pixel at (8,8)
    set_config(16, 1, 1, 1, 16, 16);
    send_frame(8 * 16 + 10, 1'b1, 1'b1);
    // largest block with an exact fit: no size error, no sample this early
    set_config(64, 63, 63, 1, 4032, 4032);
    send_frame(4, 1'b1, 1'b0);
    // zero scale acts as one
    set_config(0, 2, 3, 1, 4, 3);
    send_frame(12, 1'b1, 1'b0);
    // scale codes above 64 clamp, here enough for a size error
    set_config(127, 1, 1, 1, 63, 4095);
    send_frame(2, 1'b1, 1'b0);
    set_config(127, 4095, 4095, 0, 4095, 4095);
    send_frame(2, 1'b1, 1'b0);
  endtask

  task automatic test_wide_source();
    // largest source, single output: the first pixel is the whole frame
    set_config(1, 1, 1, 0, 4095, 4095);
    send_frame(3, 1'b1, 1'b0);
    // largest output size: first pixels of the top row come straight out
    set_config(1, 4095, 4095, 1, 4095, 4095);
    send_frame(3, 1'b1, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned sc, s, rows, cols, w, h, ctr, kind, r, n;
    fed_items = 0;
    while (fed_items < RANDOM_ITEMS) begin
      r    = $urandom_range(0, 19);
      sc   = $urandom_range(1, 3);
      rows = $urandom_range(1, 3);
      cols = $urandom_range(1, 3);
      ctr  = $urandom_range(0, 1);
      if (r == 0) sc = 0;
      s = (sc == 0) ? 1 : sc;
      if (r == 2 || r == 3) begin
        rows = $urandom_range(2, 3);
        cols = $urandom_range(2, 3);
      end
      w = cols * s + $urandom_range(0, 3);
      h = rows * s + $urandom_range(0, 3);
      case (r)
        1: sc = $urandom_range(65, 127);
        2: w = cols * s - 1;
        3: h = rows * s - 1;
        4: if ($urandom_range(0, 1)) rows = 0; else cols = 0;
        default: ;
      endcase
      set_config(sc, rows, cols, ctr, w, h);
      no_idle = ($urandom_range(0, 6) == 0);
      repeat ($urandom_range(2, 4)) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          send_frame(w * h, 1'b1, 1'b1);
        end else if (kind < 80) begin
          // cut short; the next frame start restarts the walk
          send_frame($urandom_range(1, w * h), 1'b1, 1'b1);
        end else if (kind < 90) begin
          send_frame(w * h + $urandom_range(1, 5), 1'b1, 1'b1);
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) send_pixel(rand_pixel(), $urandom_range(0, 3) == 0);
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // Result stall: random, none while no_idle is set, or one long hold-off when asked
  initial begin
    int unsigned len;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
        out_stall <= 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        len = pick_gap();
        if (len > 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
                                      input logic [PIX_W-1:0] got);
    if (want !== got) begin
      if (errors < MAX_REPORTS) $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Result checker: each accepted item against the oldest sampled pixel
  always @(posedge clk) begin
    crop_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (sampled_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $error("unexpected item: pixel_out %0h frame_last %0b size_error %0b",
                 pixel_out, frame_last, size_error);
        errors++;
      end else begin
        want = sampled_q.pop_front();
        check_field("pixel_out", want.pixel, pixel_out);
        check_field("frame_last", want.last, frame_last);
        check_field("size_error", want.size_err, size_error);
      end
    end
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_SCALE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    pixel_in     = '0;
    frame_start  = 1'b0;
    // register copies and walk at their reset values
    reg_scale    = SCALE_RST;
    reg_out_rows = OUT_DIM_RST;
    reg_out_cols = OUT_DIM_RST;
    reg_center   = 1'b1;
    reg_src_w    = SRC_DIM_RST;
    reg_src_h    = SRC_DIM_RST;
    walk_col = '0; walk_row = '0; col_ph = '0; row_ph = '0;
    blk_col = '0; blk_row = '0;
    frame_idle = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_back_pressure();
    test_scale_limits();
    test_wide_source();
    test_random_frames();

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && sampled_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ccd_pkg.sv
hdl/center_crop_decimator.sv
verif/tb_top.sv
